### rtl/sgpt_pkg.sv
// ----------------------------------------------------------------------------
// sgpt_pkg: shared constants and types
// Widths of the candidate, its partner 2n+1, the trial divisor and the
// divisor square, plus the control and status words of the modulo unit.
// ----------------------------------------------------------------------------
package sgpt_pkg;

  localparam int NUMBER_BITS  = 31;
  localparam int PARTNER_BITS = NUMBER_BITS + 1;
  // trial divisor stays below sqrt(2^PARTNER_BITS) + 2
  localparam int DIV_BITS     = PARTNER_BITS / 2 + 1;
  // (d + 2)^2 for the largest divisor still fits here
  localparam int SQ_BITS      = PARTNER_BITS + 2;
  localparam int CNT_BITS     = $clog2(PARTNER_BITS + 1);

  typedef struct packed {
    logic start;
  } sgpt_mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } sgpt_mod_st_t;

endpackage

### rtl/sgpt_mod.sv
// ----------------------------------------------------------------------------
// sgpt_mod: bit-serial remainder unit
// Restoring division of a PARTNER_BITS-wide dividend by a DIV_BITS-wide
// divisor, one quotient bit per cycle; reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module sgpt_mod import sgpt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sgpt_mod_ctl_t           ctl_i,
  input  logic [PARTNER_BITS-1:0] dividend_i,
  input  logic [DIV_BITS-1:0]     divisor_i,
  output sgpt_mod_st_t            st_o
);

  logic [PARTNER_BITS-1:0] dvd_q, dvd_d;
  logic [DIV_BITS:0]       rem_q, rem_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_BITS:0]       trial;

  // shift in the next dividend bit; divisor must hold while busy
  assign trial = {rem_q[DIV_BITS-1:0], dvd_q[PARTNER_BITS-1]};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_BITS'(PARTNER_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[PARTNER_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign st_o.busy     = busy_q;
  assign st_o.done     = done_q;
  assign st_o.rem_zero = (rem_q == '0);

endmodule

### rtl/sophie_germain_prime_test_top.sv
// ----------------------------------------------------------------------------
// sophie_germain_prime_test_top: Sophie Germain test by trial division
//
//   channel  valid        stall        payload
//   in       in_valid_i   in_stall_o   number_i
//   out      out_valid_o  out_stall_i  invalid_o, partner_o, number_is_prime_o,
//                                      partner_is_prime_o, is_sophie_germain_o
//
// Tests n, then 2n+1, by odd trial divisors while d*d <= value. Each trial
// is a square compare in the check state, then a remainder in the shared
// bit-serial remainder unit. A zero word skips the tests, n of 1 or 2 needs
// no remainder, and n near 2^31 with n and 2n+1 both prime needs about
// 23170 + 32767 trials.
// Reset clears the sequencer and the output valid; nothing else needs it.
// in_stall_o stays high while a word is in work; a stalled result holds in the
// output register, a new result waits in the done state until it has moved on,
// and the next word is taken once the new result is in the output register.
// ----------------------------------------------------------------------------
module sophie_germain_prime_test_top import sgpt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [NUMBER_BITS-1:0]  number_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    invalid_o,
  output logic [PARTNER_BITS-1:0] partner_o,
  output logic                    number_is_prime_o,
  output logic                    partner_is_prime_o,
  output logic                    is_sophie_germain_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_CHECK = 6'b000100,
    S_MOD   = 6'b001000,
    S_NEXT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [PARTNER_BITS-1:0] v_q, v_d;
  logic [PARTNER_BITS-1:0] partner_q, partner_d;
  logic [DIV_BITS-1:0]     d_q, d_d;
  logic [SQ_BITS-1:0]      sq_q, sq_d;
  logic                    phase_q, phase_d;
  logic                    flag_q, flag_d;
  logic                    np_q, np_d;
  logic                    pp_q, pp_d;
  logic                    inv_q, inv_d;
  logic                    out_valid_q, out_valid_d;
  logic                    in_acc;
  logic                    out_free;
  sgpt_mod_ctl_t           mod_ctl;
  sgpt_mod_st_t            mod_st;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  sgpt_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mod_ctl),
    .dividend_i (v_q),
    .divisor_i  (d_q),
    .st_o       (mod_st)
  );

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    partner_d   = partner_q;
    d_d         = d_q;
    sq_d        = sq_q;
    phase_d     = phase_q;
    flag_d      = flag_q;
    np_d        = np_q;
    pp_d        = pp_q;
    inv_d       = inv_q;
    out_valid_d = out_valid_q && out_stall_i;
    mod_ctl     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          v_d       = {1'b0, number_i};
          partner_d = {number_i, 1'b1};
          phase_d   = 1'b0;
          np_d      = 1'b0;
          pp_d      = 1'b0;
          if (number_i == '0) begin
            inv_d     = 1'b1;
            partner_d = '0;
            state_d   = S_DONE;
          end else begin
            inv_d   = 1'b0;
            state_d = S_START;
          end
        end
      end
      S_START: begin
        d_d  = DIV_BITS'(3);
        sq_d = SQ_BITS'(9);
        if (v_q[PARTNER_BITS-1:1] == '0) begin
          flag_d  = 1'b0;
          state_d = S_NEXT;
        end else if (v_q == PARTNER_BITS'(2)) begin
          flag_d  = 1'b1;
          state_d = S_NEXT;
        end else if (!v_q[0]) begin
          flag_d  = 1'b0;
          state_d = S_NEXT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sq_q > {2'b00, v_q}) begin
          flag_d  = 1'b1;
          state_d = S_NEXT;
        end else begin
          mod_ctl.start = 1'b1;
          state_d       = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_st.done) begin
          if (mod_st.rem_zero) begin
            flag_d  = 1'b0;
            state_d = S_NEXT;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_d     = d_q + DIV_BITS'(2);
            sq_d    = sq_q + {{(SQ_BITS-DIV_BITS-2){1'b0}}, d_q, 2'b00} + SQ_BITS'(4);
            state_d = S_CHECK;
          end
        end
      end
      S_NEXT: begin
        if (!phase_q) begin
          np_d    = flag_q;
          v_d     = partner_q;
          phase_d = 1'b1;
          state_d = S_START;
        end else begin
          pp_d    = flag_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    partner_q <= partner_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    phase_q   <= phase_d;
    flag_q    <= flag_d;
    np_q      <= np_d;
    pp_q      <= pp_d;
    inv_q     <= inv_d;
  end

  // output word register: load on the move out of the done state
  logic                    res_inv_q;
  logic [PARTNER_BITS-1:0] res_partner_q;
  logic                    res_np_q;
  logic                    res_pp_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      res_inv_q     <= inv_q;
      res_partner_q <= partner_q;
      res_np_q      <= np_q;
      res_pp_q      <= pp_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign invalid_o           = res_inv_q;
  assign partner_o           = res_partner_q;
  assign number_is_prime_o   = res_np_q;
  assign partner_is_prime_o  = res_pp_q;
  assign is_sophie_germain_o = res_np_q && res_pp_q;

  a_done_in_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_st.done |-> state_q == S_MOD)
    else $error("remainder done outside trial wait");

  a_odd_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> d_q[0] && v_q[0])
    else $error("even divisor or even value in trial loop");

  a_invalid_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> partner_o == '0 && !number_is_prime_o
                                 && !partner_is_prime_o)
    else $error("invalid word carries flags or partner");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after accept");

endmodule

### verif/sophie_germain_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sophie_germain_checker: result predictor and scoreboard
// Watches both channels of the Sophie Germain tester. Each accepted input word
// gets its expected result from a trial-division predictor, and each accepted
// result word is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module sophie_germain_checker import sgpt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [NUMBER_BITS-1:0]  number_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic                    invalid_i,
  input  logic [PARTNER_BITS-1:0] partner_i,
  input  logic                    number_is_prime_i,
  input  logic                    partner_is_prime_i,
  input  logic                    is_sophie_germain_i,
  output int                      error_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic                    invalid;
    logic [PARTNER_BITS-1:0] partner;
    logic                    number_is_prime;
    logic                    partner_is_prime;
    logic                    is_sophie_germain;
  } sg_verdict_t;

  sg_verdict_t verdicts_due [$];
  int          mismatches = 0;
  int          outstanding = 0;

  assign error_count_o = mismatches;
  assign pending_o     = outstanding;

  function automatic bit prime_by_division(input longint unsigned v);
    longint unsigned d;
    if (v < 2) return 1'b0;
    if (v == 2) return 1'b1;
    if (v[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= v; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic sg_verdict_t predict_sophie_germain(input logic [NUMBER_BITS-1:0] n);
    sg_verdict_t     r;
    longint unsigned p;
    r = '0;
    if (n == '0) begin
      r.invalid = 1'b1;
      return r;
    end
    p = n;
    p = 2 * p + 1;
    r.partner           = p[PARTNER_BITS-1:0];
    r.number_is_prime   = prime_by_division(n);
    r.partner_is_prime  = prime_by_division(p);
    r.is_sophie_germain = r.number_is_prime && r.partner_is_prime;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    sg_verdict_t want;
    if (rst_ni) begin
      // retire the result before queuing a new word
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          $error("result word with nothing expected: partner %0d", partner_i);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("invalid", want.invalid, invalid_i);
          check_field("partner", want.partner, partner_i);
          check_field("number_is_prime", want.number_is_prime, number_is_prime_i);
          check_field("partner_is_prime", want.partner_is_prime, partner_is_prime_i);
          check_field("is_sophie_germain", want.is_sophie_germain, is_sophie_germain_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        verdicts_due.push_back(predict_sophie_germain(number_i));
      outstanding = verdicts_due.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: Sophie Germain tester top-level test
// Sends directed corner values, then mostly small random candidates with a few
// large ones built to have small factors, under random idle and stall bursts.
// ----------------------------------------------------------------------------
module testbench import sgpt_pkg::*;;

  localparam int RANDOM_WORDS = 75;
  localparam int QUIET_WORDS  = 20;
  // the quiet limit lies far above the run of a word with n and 2n+1 both prime near the top
  localparam int IDLE_LIMIT   = 10_000_000;
  localparam int DRAIN_CYCLES = 50;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [NUMBER_BITS-1:0]  number;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    invalid;
  logic [PARTNER_BITS-1:0] partner;
  logic                    number_is_prime;
  logic                    partner_is_prime;
  logic                    is_sophie_germain;

  int  error_count;
  int  pending;
  bit  idle_on = 1'b1;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  logic [NUMBER_BITS-1:0] directed_words [$] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7, 31'd9, 31'd11, 31'd12,
    31'd15, 31'd23, 31'd24, 31'd29, 31'd41, 31'd83, 31'd89, 31'd113, 31'd1019,
    31'h0001_0000, 31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA,
    31'h7FFF_FFFE, 31'h7FFF_FFFF
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sophie_germain_prime_test_top DUT (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .number_i            (number),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .invalid_o           (invalid),
    .partner_o           (partner),
    .number_is_prime_o   (number_is_prime),
    .partner_is_prime_o  (partner_is_prime),
    .is_sophie_germain_o (is_sophie_germain)
  );

  sophie_germain_checker checker_i (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .number_i            (number),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .invalid_i           (invalid),
    .partner_i           (partner),
    .number_is_prime_i   (number_is_prime),
    .partner_is_prime_i  (partner_is_prime),
    .is_sophie_germain_i (is_sophie_germain),
    .error_count_o       (error_count),
    .pending_o           (pending)
  );

  // Large candidate whose trials end early: 6k+4 is even with 3 | 2n+1,
  // 30k+25 has 5 | n and 3 | 2n+1.
  function automatic logic [NUMBER_BITS-1:0] large_quick_number();
    logic [31:0] k;
    if ($urandom_range(0, 1) == 0) begin
      k = $urandom_range(0, 357913940);
      return NUMBER_BITS'(6 * k + 4);
    end
    k = $urandom_range(0, 71582787);
    return NUMBER_BITS'(30 * k + 25);
  endfunction

  task automatic send_number(input logic [NUMBER_BITS-1:0] n);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    number   <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result-side stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 11) - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [NUMBER_BITS-1:0] n;
    int                     w;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    number   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i]) send_number(directed_words[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - QUIET_WORDS) idle_on = 1'b0;
      if ($urandom_range(0, 99) < 80) begin
        w = $urandom_range(1, 12);
        n = NUMBER_BITS'($urandom & ((32'd1 << w) - 1));
      end else begin
        n = large_quick_number();
      end
      send_number(n);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
